@@ rtl/core/formation_goal_generator_macros.svh @@
// Assertion macros shared by the formation goal generator RTL.
`ifndef FORMATION_GOAL_GENERATOR_MACROS_SVH
`define FORMATION_GOAL_GENERATOR_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define FGG_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define FGG_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fgg_pkg.sv @@
// Shared types, constants and tables of the formation goal generator.
package fgg_pkg;

    localparam int NUM_ROBOTS_DEF = 4;
    localparam int NUM_SLOTS_DEF  = 3;

    localparam int POS_W  = 32;
    localparam int HD_W   = 16;
    localparam int SP_W   = 16;
    localparam int H_W    = 4;   // slot offset in half units, -6..6
    localparam int TRIG_W = 32;  // Q2.30 cosine / sine
    localparam int ANG_W  = 33;  // CORDIC residual angle

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic [TRIG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    localparam logic [SP_W-1:0] MIN_SPACING   = 16'd128;
    localparam logic [SP_W-1:0] SPACING_RESET = 16'd256;

    // register indexes
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_SPACING = 2'd1;
    localparam logic [1:0] REG_LEADER  = 2'd2;

    // request kinds
    localparam logic REQ_POSE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // formation modes
    localparam logic [2:0] MODE_SQUARE  = 3'd0;
    localparam logic [2:0] MODE_DIAMOND = 3'd1;
    localparam logic [2:0] MODE_COLUMN  = 3'd2;
    localparam logic [2:0] MODE_LINE    = 3'd3;
    localparam logic [2:0] MODE_ESCORT  = 3'd4;

    typedef struct packed {
        logic signed [H_W-1:0] hx;
        logic signed [H_W-1:0] hy;
    } t_slot_ofs;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } t_trig;

    function automatic t_slot_ofs mk_ofs(input int hx, input int hy);
        t_slot_ofs o;
        o.hx = H_W'(hx);
        o.hy = H_W'(hy);
        return o;
    endfunction

    // Slot offsets in half units. Unused modes fall to square.
    function automatic t_slot_ofs slot_offset(input logic [2:0] mode, input logic [1:0] slot);
        t_slot_ofs o;
        o = mk_ofs(0, 0);
        unique case (mode)
            MODE_DIAMOND: begin
                unique case (slot)
                    2'd0:    o = mk_ofs(-2, 0);
                    2'd1:    o = mk_ofs(0, -2);
                    2'd2:    o = mk_ofs(2, 0);
                    default: o = mk_ofs(0, 0);
                endcase
            end
            MODE_COLUMN: begin
                unique case (slot)
                    2'd0:    o = mk_ofs(0, -2);
                    2'd1:    o = mk_ofs(0, -4);
                    2'd2:    o = mk_ofs(0, -6);
                    default: o = mk_ofs(0, 0);
                endcase
            end
            MODE_LINE: begin
                unique case (slot)
                    2'd0:    o = mk_ofs(0, 2);
                    2'd1:    o = mk_ofs(0, 4);
                    2'd2:    o = mk_ofs(0, 6);
                    default: o = mk_ofs(0, 0);
                endcase
            end
            MODE_ESCORT: begin
                unique case (slot)
                    2'd0:    o = mk_ofs(2, 0);
                    2'd1:    o = mk_ofs(-2, -1);
                    2'd2:    o = mk_ofs(-2, 1);
                    default: o = mk_ofs(0, 0);
                endcase
            end
            default: begin
                unique case (slot)
                    2'd0:    o = mk_ofs(-2, 0);
                    2'd1:    o = mk_ofs(0, -2);
                    2'd2:    o = mk_ofs(-2, -2);
                    default: o = mk_ofs(0, 0);
                endcase
            end
        endcase
        return o;
    endfunction

endpackage

@@ rtl/core/fgg_pose_store.sv @@
// Per-robot pose registers with valid bits cleared at reset.
module fgg_pose_store #(
    parameter  int NUM_ROBOTS = fgg_pkg::NUM_ROBOTS_DEF,
    localparam int IDX_W      = (NUM_ROBOTS > 1) ? $clog2(NUM_ROBOTS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [IDX_W-1:0]                    i_wr_idx,
    input  logic signed [fgg_pkg::POS_W-1:0]    i_wr_x,
    input  logic signed [fgg_pkg::POS_W-1:0]    i_wr_y,
    input  logic signed [fgg_pkg::HD_W-1:0]     i_wr_hd,
    input  logic [IDX_W-1:0]                    i_rd_idx,
    output logic signed [fgg_pkg::POS_W-1:0]    o_rd_x,
    output logic signed [fgg_pkg::POS_W-1:0]    o_rd_y,
    output logic signed [fgg_pkg::HD_W-1:0]     o_rd_hd,
    output logic                                o_rd_known
);
    logic signed [fgg_pkg::POS_W-1:0] r_x  [NUM_ROBOTS];
    logic signed [fgg_pkg::POS_W-1:0] r_y  [NUM_ROBOTS];
    logic signed [fgg_pkg::HD_W-1:0]  r_hd [NUM_ROBOTS];
    logic [NUM_ROBOTS-1:0]            r_known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= '0;
        end else if (i_wr_en) begin
            r_known[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_x[i_wr_idx]  <= i_wr_x;
            r_y[i_wr_idx]  <= i_wr_y;
            r_hd[i_wr_idx] <= i_wr_hd;
        end
    end

    assign o_rd_x     = r_x[i_rd_idx];
    assign o_rd_y     = r_y[i_rd_idx];
    assign o_rd_hd    = r_hd[i_rd_idx];
    assign o_rd_known = r_known[i_rd_idx];

endmodule

@@ rtl/core/fgg_cordic.sv @@
// Iterative CORDIC: cosine and sine of a binary angle, one step per cycle.
module fgg_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [fgg_pkg::HD_W-1:0]   i_heading,
    output logic                              o_done,
    output fgg_pkg::t_trig                    o_trig
);
    localparam int TW = fgg_pkg::TRIG_W;
    localparam int AW = fgg_pkg::ANG_W;
    localparam logic [4:0] LAST_STEP = 5'(fgg_pkg::CORDIC_STEPS - 1);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_i;
    logic              r_flip;
    logic signed [TW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    fgg_pkg::t_trig    r_trig;

    logic              n_flip;
    logic [TW-1:0]     start_ang;
    logic signed [TW-1:0] dx, dy, n_x, n_y;
    logic signed [AW-1:0] atan_ext, n_z;

    // turn by 180 degrees when beyond +-90, undo by negating at the end
    assign n_flip    = i_heading[15] ^ i_heading[14];
    assign start_ang = {i_heading[15] ^ n_flip, i_heading[14:0], 16'h0000};

    assign dx       = r_y >>> r_i;
    assign dy       = r_x >>> r_i;
    assign atan_ext = $signed({1'b0, fgg_pkg::ATAN_TAB[r_i]});

    always_comb begin
        if (!r_z[AW-1]) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - atan_ext;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + atan_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 5'd1;
                if (r_i == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= fgg_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= $signed({start_ang[TW-1], start_ang});
            r_flip <= n_flip;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            if (r_i == LAST_STEP) begin
                r_trig.c <= r_flip ? -n_x : n_x;
                r_trig.s <= r_flip ? -n_y : n_y;
            end
        end
    end

    assign o_done = r_done;
    assign o_trig = r_trig;

endmodule

@@ rtl/core/fgg_rotate.sv @@
// Shared multiplier sequence: scales, rotates and offsets one slot goal.
module fgg_rotate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  fgg_pkg::t_slot_ofs                i_ofs,
    input  logic [fgg_pkg::SP_W-1:0]          i_spacing,
    input  fgg_pkg::t_trig                    i_trig,
    input  logic signed [fgg_pkg::POS_W-1:0]  i_lead_x,
    input  logic signed [fgg_pkg::POS_W-1:0]  i_lead_y,
    output logic                              o_done,
    output logic signed [fgg_pkg::POS_W-1:0]  o_goal_x,
    output logic signed [fgg_pkg::POS_W-1:0]  o_goal_y
);
    localparam int HW    = fgg_pkg::H_W;
    localparam int SW    = fgg_pkg::SP_W;
    localparam int TW    = fgg_pkg::TRIG_W;
    localparam int PW    = fgg_pkg::POS_W;
    localparam int A_W   = HW + SW + 1;    // half offset times spacing
    localparam int P_W   = A_W + TW;       // product
    localparam int ACC_W = P_W + 1;
    localparam int RSH   = 23;             // x128 scale and Q2.30 -> Q16.16
    localparam int RX_W  = ACC_W - RSH;
    localparam int SUM_W = PW + 2;

    localparam logic [2:0] CNT_ACC_X0 = 3'd2;
    localparam logic [2:0] CNT_ACC_X1 = 3'd3;
    localparam logic [2:0] CNT_ACC_Y0 = 3'd4;
    localparam logic [2:0] CNT_ACC_Y1 = 3'd5;
    localparam logic [2:0] CNT_ROUND  = 3'd6;
    localparam logic [2:0] CNT_SAT    = 3'd7;

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'd1 << (RSH - 1));

    logic                    r_busy;
    logic                    r_done;
    logic [2:0]              r_cnt;
    logic signed [A_W-1:0]   r_a;
    logic signed [TW-1:0]    r_b;
    logic signed [P_W-1:0]   r_p;
    logic signed [ACC_W-1:0] r_acc_x, r_acc_y;
    logic signed [RX_W-1:0]  r_rx, r_ry;
    logic signed [PW-1:0]    r_gx, r_gy;

    logic signed [HW-1:0]    h_sel;
    logic signed [TW-1:0]    t_sel;
    logic signed [A_W-1:0]   n_a;
    logic signed [P_W-1:0]   a_ext, b_ext;
    logic signed [ACC_W-1:0] p_ext, rnd_x, rnd_y;
    logic signed [SUM_W-1:0] sum_x, sum_y;

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic hi_same;
        hi_same = (v[SUM_W-1:PW-1] == '0) || (v[SUM_W-1:PW-1] == '1);
        if (hi_same) begin
            return v[PW-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(PW-1){1'b0}}};
        end else begin
            return {1'b0, {(PW-1){1'b1}}};
        end
    endfunction

    // issue order: hx*c, hy*s, hx*s, hy*c
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin h_sel = i_ofs.hx; t_sel = i_trig.c; end
            2'd1: begin h_sel = i_ofs.hy; t_sel = i_trig.s; end
            2'd2: begin h_sel = i_ofs.hx; t_sel = i_trig.s; end
            default: begin h_sel = i_ofs.hy; t_sel = i_trig.c; end
        endcase
    end

    assign n_a   = $signed({{(A_W-HW){h_sel[HW-1]}}, h_sel})
                 * $signed({{(A_W-SW){1'b0}}, i_spacing});
    assign a_ext = $signed({{(P_W-A_W){r_a[A_W-1]}}, r_a});
    assign b_ext = $signed({{(P_W-TW){r_b[TW-1]}}, r_b});
    assign p_ext = $signed({r_p[P_W-1], r_p});
    assign rnd_x = r_acc_x + HALF_LSB;
    assign rnd_y = r_acc_y + HALF_LSB;
    assign sum_x = $signed({{(SUM_W-PW){i_lead_x[PW-1]}}, i_lead_x})
                 + $signed({{(SUM_W-RX_W){r_rx[RX_W-1]}}, r_rx});
    assign sum_y = $signed({{(SUM_W-PW){i_lead_y[PW-1]}}, i_lead_y})
                 + $signed({{(SUM_W-RX_W){r_ry[RX_W-1]}}, r_ry});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == CNT_SAT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= t_sel;
        r_p <= a_ext * b_ext;
        if (r_busy) begin
            unique case (r_cnt)
                CNT_ACC_X0: r_acc_x <= p_ext;
                CNT_ACC_X1: r_acc_x <= r_acc_x - p_ext;
                CNT_ACC_Y0: r_acc_y <= p_ext;
                CNT_ACC_Y1: r_acc_y <= r_acc_y + p_ext;
                CNT_ROUND: begin
                    r_rx <= rnd_x[ACC_W-1:RSH];
                    r_ry <= rnd_y[ACC_W-1:RSH];
                end
                CNT_SAT: begin
                    r_gx <= sat_pos(sum_x);
                    r_gy <= sat_pos(sum_y);
                end
                default: ;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_goal_x = r_gx;
    assign o_goal_y = r_gy;

endmodule

@@ rtl/core/formation_goal_generator.sv @@
// Formation goal generator top level: pose store, tick sequencer, goal output.
//
// Input stream (s_axis): one beat is a pose update (tuser = 0) or a tick (tuser = 1).
//   A pose update stores robot_index's position and heading and marks it known;
//   it yields no output beat.
// A tick with the leader's pose unknown is dropped. Otherwise the leader's
//   heading goes through a 30-step CORDIC (one step per cycle), then robots
//   are walked in index order: the leader gets its own pose, each follower
//   takes the next formation slot and goes through the shared multiplier
//   sequence (four products, round, saturate). Robots past the last slot are
//   skipped until the leader is reached.
// The length of a full tick is set by the CORDIC loop and the single shared
//   multiplier.
// Output stream (m_axis): one beat per goal, tlast on the final goal of the tick.
//   The output register lets the sequencer run on while a beat waits; a stalled
//   receiver stops the sequencer at its next goal. s_axis_tready is high only
//   between ticks, so pose updates are taken even while the last goal waits.
// Configuration (i_cfg_*): plain writes, to be issued only while idle since a tick
//   reads them throughout. Spacing writes below 0.5 m store 0.5 m; leader writes
//   past the robot count are ignored.
// Reset (synchronous, active low) clears all known marks, the registers to their
//   defaults and any tick in flight.
module formation_goal_generator #(
    parameter int NUM_ROBOTS = fgg_pkg::NUM_ROBOTS_DEF,
    parameter int NUM_SLOTS  = fgg_pkg::NUM_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // robot_index[1:0], pos_x[33:2], pos_y[65:34],
                                        // heading[81:66], zero pad
    input  logic [0:0]  s_axis_tuser,   // req_type[0]
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // goal_robot[1:0], goal_x[33:2], goal_y[65:34],
                                        // goal_heading[81:66], zero pad
    output logic        m_axis_tlast,   // last_goal
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    `include "formation_goal_generator_macros.svh"

    localparam int IDX_W = (NUM_ROBOTS > 1) ? $clog2(NUM_ROBOTS) : 1;
    localparam int PW    = fgg_pkg::POS_W;
    localparam int HW    = fgg_pkg::HD_W;
    localparam int NUM_FOLLOW = (NUM_ROBOTS - 1 < NUM_SLOTS) ? NUM_ROBOTS - 1 : NUM_SLOTS;
    localparam logic [1:0] LAST_EMIT = 2'(NUM_FOLLOW);   // goals per tick minus one
    localparam logic [1:0] SLOT_LIM  = 2'(NUM_SLOTS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CORDIC = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_ROT    = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    // configuration registers
    logic [2:0]             r_mode;
    logic [fgg_pkg::SP_W-1:0] r_spacing;
    logic [1:0]             r_leader;

    // sequencer
    logic [2:0]             r_state, n_state;
    logic [IDX_W-1:0]       r_robot;
    logic [1:0]             r_slot;
    logic [1:0]             r_emit;
    logic signed [PW-1:0]   r_lx, r_ly;
    logic signed [HW-1:0]   r_lh;

    // output register
    logic                   r_out_valid;
    logic                   r_out_last;
    logic [1:0]             r_out_robot;
    logic signed [PW-1:0]   r_out_x, r_out_y;
    logic signed [HW-1:0]   r_out_hd;

    logic                   in_accept, is_tick, pose_wr, tick_go;
    logic [1:0]             in_robot;
    logic signed [PW-1:0]   in_x, in_y;
    logic signed [HW-1:0]   in_hd;
    logic [IDX_W+1:0]       wr_ext, lead_ext, robot_ext;
    logic                   is_leader, out_free, emit_fire, emit_last, rot_start;
    logic [2:0]             mode_eff;
    logic signed [PW-1:0]   st_x, st_y;
    logic signed [HW-1:0]   st_hd;
    logic                   lead_known;
    logic                   cordic_done, rot_done;
    fgg_pkg::t_trig         trig;
    fgg_pkg::t_slot_ofs     ofs;
    logic signed [PW-1:0]   rot_x, rot_y;

    assign in_robot = s_axis_tdata[1:0];
    assign in_x     = $signed(s_axis_tdata[33:2]);
    assign in_y     = $signed(s_axis_tdata[65:34]);
    assign in_hd    = $signed(s_axis_tdata[81:66]);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_tick       = (s_axis_tuser[0] == fgg_pkg::REQ_TICK);
    assign pose_wr       = in_accept && !is_tick && (int'(in_robot) < NUM_ROBOTS);
    assign tick_go       = in_accept && is_tick && lead_known;

    assign wr_ext    = {{IDX_W{1'b0}}, in_robot};
    assign lead_ext  = {{IDX_W{1'b0}}, r_leader};
    assign robot_ext = {2'b00, r_robot};
    assign is_leader = (robot_ext == lead_ext);

    // modes past escort behave as square
    assign mode_eff = (r_mode <= fgg_pkg::MODE_ESCORT) ? r_mode : fgg_pkg::MODE_SQUARE;
    assign ofs      = fgg_pkg::slot_offset(mode_eff, r_slot);

    assign out_free  = !r_out_valid || m_axis_tready;
    assign emit_fire = (r_state == ST_EMIT) && out_free;
    assign emit_last = (r_emit == LAST_EMIT);
    assign rot_start = (r_state == ST_SCAN) && !is_leader && (r_slot < SLOT_LIM);

    fgg_pose_store #(
        .NUM_ROBOTS (NUM_ROBOTS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (pose_wr),
        .i_wr_idx   (wr_ext[IDX_W-1:0]),
        .i_wr_x     (in_x),
        .i_wr_y     (in_y),
        .i_wr_hd    (in_hd),
        .i_rd_idx   (lead_ext[IDX_W-1:0]),
        .o_rd_x     (st_x),
        .o_rd_y     (st_y),
        .o_rd_hd    (st_hd),
        .o_rd_known (lead_known)
    );

    fgg_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (tick_go),
        .i_heading (st_hd),
        .o_done    (cordic_done),
        .o_trig    (trig)
    );

    fgg_rotate u_rotate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rot_start),
        .i_ofs     (ofs),
        .i_spacing (r_spacing),
        .i_trig    (trig),
        .i_lead_x  (r_lx),
        .i_lead_y  (r_ly),
        .o_done    (rot_done),
        .o_goal_x  (rot_x),
        .o_goal_y  (rot_y)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= fgg_pkg::MODE_SQUARE;
            r_spacing <= fgg_pkg::SPACING_RESET;
            r_leader  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fgg_pkg::REG_MODE:    r_mode <= i_cfg_wdata[2:0];
                fgg_pkg::REG_SPACING: begin
                    r_spacing <= (i_cfg_wdata < fgg_pkg::MIN_SPACING) ?
                                 fgg_pkg::MIN_SPACING : i_cfg_wdata;
                end
                fgg_pkg::REG_LEADER: begin
                    if (int'(i_cfg_wdata[1:0]) < NUM_ROBOTS) begin
                        r_leader <= i_cfg_wdata[1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // tick sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (tick_go)     n_state = ST_CORDIC;
            ST_CORDIC: if (cordic_done) n_state = ST_SCAN;
            ST_SCAN: begin
                if (is_leader) begin
                    n_state = ST_EMIT;
                end else if (r_slot < SLOT_LIM) begin
                    n_state = ST_ROT;
                end
            end
            ST_ROT:    if (rot_done)    n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = emit_last ? ST_IDLE : ST_SCAN;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_robot <= '0;
            r_slot  <= '0;
            r_emit  <= '0;
        end else begin
            r_state <= n_state;
            if (tick_go) begin
                r_robot <= '0;
                r_slot  <= '0;
                r_emit  <= '0;
            end else if (r_state == ST_SCAN && !is_leader && !(r_slot < SLOT_LIM)) begin
                // no slot left for this robot: skip it
                r_robot <= r_robot + 1'b1;
            end else if (emit_fire && !emit_last) begin
                r_robot <= r_robot + 1'b1;
                r_emit  <= r_emit + 2'd1;
                if (!is_leader) begin
                    r_slot <= r_slot + 2'd1;
                end
            end
        end
    end

    // leader pose snapshot for the whole tick
    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_lx <= st_x;
            r_ly <= st_y;
            r_lh <= st_hd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_last  <= emit_last;
            r_out_robot <= robot_ext[1:0];
            r_out_x     <= is_leader ? r_lx : rot_x;
            r_out_y     <= is_leader ? r_ly : rot_y;
            r_out_hd    <= r_lh;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {6'd0, r_out_hd, r_out_y, r_out_x, r_out_robot};

    // checks
    `FGG_ASSERT_IMP(a_mid_tick_busy, r_out_valid && !r_out_last, r_state != ST_IDLE,
                    "non-final goal waiting while sequencer idle")
    `FGG_ASSERT_NXT(a_unknown_leader_drop, in_accept && is_tick && !lead_known,
                    r_state == ST_IDLE, "tick without leader pose was not dropped")
    `FGG_ASSERT_IMP(a_rot_done_in_rot, rot_done, r_state == ST_ROT,
                    "rotation result outside rotation phase")
    `FGG_ASSERT_IMP(a_emit_bound, r_state != ST_IDLE, r_emit <= LAST_EMIT,
                    "goal count ran past the tick size")

endmodule
